// ----- rtl/core/viewport_zoom_pan_top_macros.svh -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan assertion macros
// Shared concurrent assertion forms for the viewport core.
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_ZOOM_PAN_TOP_MACROS_SVH
`define VIEWPORT_ZOOM_PAN_TOP_MACROS_SVH

// same-cycle implication
`define VZP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("viewport core: same-cycle check failed");

// next-cycle implication
`define VZP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("viewport core: next-cycle check failed");

`endif

// ----- rtl/core/vzp_pkg.sv -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan package
// Widths, reset values, register codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package vzp_pkg;

	localparam int MOUSE_W   = 16;
	localparam int STEP_W    = 15;
	localparam int ZOOM_W    = 16;
	localparam int CAM_W     = 32;
	localparam int PIX_W     = MOUSE_W + 1;
	localparam int FRAC_SH   = 21;
	localparam int NUM_W     = PIX_W + FRAC_SH;
	localparam int QUO_W     = NUM_W + 1;
	localparam int WORLD_W   = CAM_W + 8;
	localparam int DIFF_W    = WORLD_W + 1;
	localparam int DIV_STEPS = NUM_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int PROD_W    = 2 * ZOOM_W;
	localparam int NZ_W      = PROD_W - 14;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [ZOOM_W-1:0] ZOOM_ONE      = 16'd8192;
	localparam logic [ZOOM_W-1:0] ZOOM_MIN_RST  = 16'd819;
	localparam logic [ZOOM_W-1:0] ZOOM_MAX_RST  = 16'd40960;
	localparam logic [ZOOM_W-1:0] STEP_ONE      = 16'd16384;

	localparam logic REG_ZOOM_MIN = 1'b0;
	localparam logic REG_ZOOM_MAX = 1'b1;

	typedef struct packed {
		logic latch_in;
		logic div_start;
		logic div_delta;
		logic zoom_cap;
		logic cam_zoom;
		logic cam_pan;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic step_nz;
		logic pan;
	} sts_t;

	function automatic logic signed [CAM_W-1:0] sat_cam(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] hi;
		logic signed [DIFF_W-1:0] lo;
		hi = DIFF_W'(signed'({1'b0, {(CAM_W-1){1'b1}}}));
		lo = DIFF_W'(signed'({1'b1, {(CAM_W-1){1'b0}}}));
		if (v > hi) begin
			sat_cam = hi[CAM_W-1:0];
		end else if (v < lo) begin
			sat_cam = lo[CAM_W-1:0];
		end else begin
			sat_cam = v[CAM_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/core/vzp_if.sv -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan channel interfaces
// Pointer event channel and view result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vzp_evt_if;
	logic                                valid;
	logic                                ready;
	logic signed [vzp_pkg::MOUSE_W-1:0]  mouse_x;
	logic signed [vzp_pkg::MOUSE_W-1:0]  mouse_y;
	logic signed [vzp_pkg::STEP_W-1:0]   zoom_step;
	logic                                pan_held;

	modport source (output valid, mouse_x, mouse_y, zoom_step, pan_held, input ready);
	modport sink (input valid, mouse_x, mouse_y, zoom_step, pan_held, output ready);
endinterface

interface vzp_view_if;
	logic                               valid;
	logic                               ready;
	logic signed [vzp_pkg::CAM_W-1:0]   cam_x;
	logic signed [vzp_pkg::CAM_W-1:0]   cam_y;
	logic        [vzp_pkg::ZOOM_W-1:0]  zoom_out;

	modport source (output valid, cam_x, cam_y, zoom_out, input ready);
	modport sink (input valid, cam_x, cam_y, zoom_out, output ready);
endinterface

// ----- rtl/core/vzp_div.sv -----
// ----------------------------------------------------------------------------
// Viewport pixel-to-world divider
// Restoring divide of pixels * 2^21 by zoom, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module vzp_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [vzp_pkg::PIX_W-1:0]    pix,
	input  logic        [vzp_pkg::ZOOM_W-1:0]   den,
	output logic                                busy,
	output logic                                done,
	output logic signed [vzp_pkg::QUO_W-1:0]    quo
);

	logic                              busy_q;
	logic                              done_q;
	logic [vzp_pkg::DCNT_W-1:0]        cnt_q;
	logic [vzp_pkg::NUM_W-1:0]         num_q;
	logic [vzp_pkg::ZOOM_W-1:0]        rem_q;
	logic [vzp_pkg::ZOOM_W-1:0]        den_q;
	logic                              neg_q;

	logic [vzp_pkg::PIX_W-1:0]         mag;
	logic [vzp_pkg::ZOOM_W:0]          t1;
	logic [vzp_pkg::ZOOM_W:0]          t2;
	logic                              ge1;
	logic                              ge2;
	logic [vzp_pkg::ZOOM_W-1:0]        r1;
	logic [vzp_pkg::ZOOM_W-1:0]        r2;
	logic [vzp_pkg::NUM_W-1:0]         n1;
	logic [vzp_pkg::NUM_W-1:0]         n2;
	logic signed [vzp_pkg::QUO_W-1:0]  qpos;

	assign mag = pix[vzp_pkg::PIX_W-1] ? vzp_pkg::PIX_W'(-pix) : vzp_pkg::PIX_W'(pix);

	always_comb begin
		t1  = {rem_q, num_q[vzp_pkg::NUM_W-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? vzp_pkg::ZOOM_W'(t1 - {1'b0, den_q}) : t1[vzp_pkg::ZOOM_W-1:0];
		n1  = {num_q[vzp_pkg::NUM_W-2:0], ge1};
		t2  = {r1, n1[vzp_pkg::NUM_W-1]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? vzp_pkg::ZOOM_W'(t2 - {1'b0, den_q}) : t2[vzp_pkg::ZOOM_W-1:0];
		n2  = {n1[vzp_pkg::NUM_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == vzp_pkg::DCNT_W'(vzp_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mag, {vzp_pkg::FRAC_SH{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			neg_q <= pix[vzp_pkg::PIX_W-1];
		end else if (busy_q) begin
			num_q <= n2;
			rem_q <= r2;
		end
	end

	assign qpos = signed'({1'b0, num_q});
	assign quo  = neg_q ? -qpos : qpos;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- rtl/core/vzp_datapath.sv -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan datapath
// Camera, zoom and pointer state, zoom multiplier, x/y divider lanes.
// ----------------------------------------------------------------------------
`include "viewport_zoom_pan_top_macros.svh"

module vzp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vzp_pkg::cmd_t                       cmd,
	output vzp_pkg::sts_t                       sts,
	input  logic signed [vzp_pkg::MOUSE_W-1:0]  mouse_x,
	input  logic signed [vzp_pkg::MOUSE_W-1:0]  mouse_y,
	input  logic signed [vzp_pkg::STEP_W-1:0]   zoom_step,
	input  logic                                pan_held,
	input  logic        [vzp_pkg::ZOOM_W-1:0]   zoom_min,
	input  logic        [vzp_pkg::ZOOM_W-1:0]   zoom_max,
	output logic signed [vzp_pkg::CAM_W-1:0]    cam_x,
	output logic signed [vzp_pkg::CAM_W-1:0]    cam_y,
	output logic        [vzp_pkg::ZOOM_W-1:0]   zoom_out
);

	logic signed [vzp_pkg::MOUSE_W-1:0]  mx_q;
	logic signed [vzp_pkg::MOUSE_W-1:0]  my_q;
	logic signed [vzp_pkg::STEP_W-1:0]   step_q;
	logic                                pan_q;
	logic signed [vzp_pkg::PIX_W-1:0]    dx_q;
	logic signed [vzp_pkg::PIX_W-1:0]    dy_q;
	logic signed [vzp_pkg::MOUSE_W-1:0]  prev_x_q;
	logic signed [vzp_pkg::MOUSE_W-1:0]  prev_y_q;
	logic signed [vzp_pkg::CAM_W-1:0]    cam_x_q;
	logic signed [vzp_pkg::CAM_W-1:0]    cam_y_q;
	logic        [vzp_pkg::ZOOM_W-1:0]   zoom_q;
	logic signed [vzp_pkg::WORLD_W-1:0]  wx_q;
	logic signed [vzp_pkg::WORLD_W-1:0]  wy_q;
	logic        [vzp_pkg::PROD_W-1:0]   prod_s1;

	logic signed [vzp_pkg::PIX_W-1:0]    pix_x;
	logic signed [vzp_pkg::PIX_W-1:0]    pix_y;
	logic        [vzp_pkg::ZOOM_W-1:0]   den;
	logic        [vzp_pkg::ZOOM_W-1:0]   factor;
	logic        [vzp_pkg::NZ_W-1:0]     nz;
	logic        [vzp_pkg::NZ_W-1:0]     nz_lo;
	logic        [vzp_pkg::ZOOM_W-1:0]   nz_cl;
	logic signed [vzp_pkg::QUO_W-1:0]    qx;
	logic signed [vzp_pkg::QUO_W-1:0]    qy;
	logic                                busy_x;
	logic                                busy_y;
	logic                                done_x;
	logic                                done_y;

	assign pix_x  = cmd.div_delta ? dx_q : vzp_pkg::PIX_W'(mx_q);
	assign pix_y  = cmd.div_delta ? dy_q : vzp_pkg::PIX_W'(my_q);
	assign den    = (zoom_q == '0) ? vzp_pkg::ZOOM_W'(1) : zoom_q;
	assign factor = vzp_pkg::ZOOM_W'(vzp_pkg::ZOOM_W'(step_q) + vzp_pkg::STEP_ONE);
	assign nz     = prod_s1[vzp_pkg::PROD_W-1:14];

	always_comb begin
		nz_lo = (nz < vzp_pkg::NZ_W'(zoom_min)) ? vzp_pkg::NZ_W'(zoom_min) : nz;
		nz_cl = (nz_lo > vzp_pkg::NZ_W'(zoom_max)) ? zoom_max : nz_lo[vzp_pkg::ZOOM_W-1:0];
	end

	vzp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.pix    (pix_x),
		.den    (den),
		.busy   (busy_x),
		.done   (done_x),
		.quo    (qx)
	);

	vzp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.pix    (pix_y),
		.den    (den),
		.busy   (busy_y),
		.done   (done_y),
		.quo    (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			zoom_q   <= vzp_pkg::ZOOM_ONE;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (cmd.latch_in) begin
				prev_x_q <= mouse_x;
				prev_y_q <= mouse_y;
			end
			if (cmd.zoom_cap) begin
				zoom_q <= nz_cl;
			end
			if (cmd.cam_zoom) begin
				cam_x_q <= vzp_pkg::sat_cam(vzp_pkg::DIFF_W'(wx_q) - vzp_pkg::DIFF_W'(qx));
				cam_y_q <= vzp_pkg::sat_cam(vzp_pkg::DIFF_W'(wy_q) - vzp_pkg::DIFF_W'(qy));
			end else if (cmd.cam_pan) begin
				cam_x_q <= vzp_pkg::sat_cam(vzp_pkg::DIFF_W'(cam_x_q) - vzp_pkg::DIFF_W'(qx));
				cam_y_q <= vzp_pkg::sat_cam(vzp_pkg::DIFF_W'(cam_y_q) - vzp_pkg::DIFF_W'(qy));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mx_q   <= mouse_x;
			my_q   <= mouse_y;
			step_q <= zoom_step;
			pan_q  <= pan_held;
			dx_q   <= vzp_pkg::PIX_W'(mouse_x) - vzp_pkg::PIX_W'(prev_x_q);
			dy_q   <= vzp_pkg::PIX_W'(mouse_y) - vzp_pkg::PIX_W'(prev_y_q);
		end
		if (cmd.div_start && !cmd.div_delta) begin
			prod_s1 <= zoom_q * factor;
		end
		if (cmd.zoom_cap) begin
			wx_q <= vzp_pkg::WORLD_W'(cam_x_q) + vzp_pkg::WORLD_W'(qx);
			wy_q <= vzp_pkg::WORLD_W'(cam_y_q) + vzp_pkg::WORLD_W'(qy);
		end
		if (cmd.load_out) begin
			cam_x    <= cam_x_q;
			cam_y    <= cam_y_q;
			zoom_out <= zoom_q;
		end
	end

	assign sts.div_done = done_x;
	assign sts.step_nz  = step_q != '0;
	assign sts.pan      = pan_q;

	`VZP_ASSERT_IMP(a_lane_sync, clk, arst_n, 1'b1, (done_x == done_y) && (busy_x == busy_y))
	`VZP_ASSERT_NXT(a_zoom_cap, clk, arst_n, cmd.zoom_cap, zoom_q <= $past(zoom_max))
	`VZP_ASSERT_IMP(a_quiet_accept, clk, arst_n, cmd.latch_in, !busy_x && !cmd.div_start)

endmodule

// ----- rtl/core/vzp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan controller
// Sequences zoom, re-anchor and pan divisions and the result register.
// ----------------------------------------------------------------------------
module vzp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_valid,
	output logic           evt_ready,
	output logic           view_valid,
	input  logic           view_ready,
	input  vzp_pkg::sts_t  sts,
	output vzp_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_ZDIV1,
		S_ZWAIT1,
		S_ZDIV2,
		S_ZWAIT2,
		S_PDIV,
		S_PWAIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   view_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_in = evt_valid;
			end
			S_ZDIV1: begin
				cmd.div_start = 1'b1;
			end
			S_ZWAIT1: begin
				cmd.zoom_cap = sts.div_done;
			end
			S_ZDIV2: begin
				cmd.div_start = 1'b1;
			end
			S_ZWAIT2: begin
				cmd.cam_zoom = sts.div_done;
			end
			S_PDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_delta = 1'b1;
			end
			S_PWAIT: begin
				cmd.div_delta = 1'b1;
				cmd.cam_pan   = sts.div_done;
			end
			S_OUT: begin
				cmd.load_out = !view_valid_q || view_ready;
			end
			S_DECIDE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			view_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				view_valid_q <= 1'b1;
			end else if (view_ready) begin
				view_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.step_nz) state_q <= S_ZDIV1;
					else if (sts.pan) state_q <= S_PDIV;
					else state_q <= S_OUT;
				end
				S_ZDIV1: begin
					state_q <= S_ZWAIT1;
				end
				S_ZWAIT1: begin
					if (sts.div_done) state_q <= S_ZDIV2;
				end
				S_ZDIV2: begin
					state_q <= S_ZWAIT2;
				end
				S_ZWAIT2: begin
					if (sts.div_done) state_q <= sts.pan ? S_PDIV : S_OUT;
				end
				S_PDIV: begin
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					if (sts.div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (cmd.load_out) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign evt_ready  = state_q == S_IDLE;
	assign view_valid = view_valid_q;

endmodule

// ----- rtl/core/viewport_zoom_pan_top.sv -----
// ----------------------------------------------------------------------------
// Viewport zoom/pan top level
// Zoom-to-cursor camera with panning, APB zoom limits, pointer event in.
// ----------------------------------------------------------------------------
// channel   role     transaction
// evt       sink     pointer event: mouse_x, mouse_y, zoom_step, pan_held
// view      source   view result: cam_x, cam_y, zoom_out
// apb       slave    zoom_min at 0x0, zoom_max at 0x4, 32-bit data
//
// An event with no zoom and no pan goes straight to the output load; pan
// alone adds one division, zoom alone two and both three; each division
// runs the two-bit-per-cycle restoring divider, one per axis side by side.
// Reset clears camera to zero, zoom to 1.0 and limits to 0.1 and 5.0.
// A held view result stalls only the final load; the next event is taken
// once the previous one has reached the output register.
// ----------------------------------------------------------------------------
module viewport_zoom_pan_top (
	input  logic                               clk,
	input  logic                               arst_n,
	vzp_evt_if.sink                            evt,
	vzp_view_if.source                         view,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [vzp_pkg::ADDR_W-1:0]         paddr,
	input  logic [vzp_pkg::DATA_W-1:0]         pwdata,
	output logic [vzp_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	logic [vzp_pkg::ZOOM_W-1:0]  zoom_min_q;
	logic [vzp_pkg::ZOOM_W-1:0]  zoom_max_q;
	logic                        reg_sel;
	vzp_pkg::cmd_t               cmd;
	vzp_pkg::sts_t               sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[vzp_pkg::ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_min_q <= vzp_pkg::ZOOM_MIN_RST;
			zoom_max_q <= vzp_pkg::ZOOM_MAX_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				vzp_pkg::REG_ZOOM_MIN: zoom_min_q <= pwdata[vzp_pkg::ZOOM_W-1:0];
				vzp_pkg::REG_ZOOM_MAX: zoom_max_q <= pwdata[vzp_pkg::ZOOM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			vzp_pkg::REG_ZOOM_MIN: prdata = vzp_pkg::DATA_W'(zoom_min_q);
			vzp_pkg::REG_ZOOM_MAX: prdata = vzp_pkg::DATA_W'(zoom_max_q);
			default:               prdata = '0;
		endcase
	end

	vzp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt.valid),
		.evt_ready  (evt.ready),
		.view_valid (view.valid),
		.view_ready (view.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	vzp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mouse_x   (evt.mouse_x),
		.mouse_y   (evt.mouse_y),
		.zoom_step (evt.zoom_step),
		.pan_held  (evt.pan_held),
		.zoom_min  (zoom_min_q),
		.zoom_max  (zoom_max_q),
		.cam_x     (view.cam_x),
		.cam_y     (view.cam_y),
		.zoom_out  (view.zoom_out)
	);

endmodule
